### rtl/core/pmbb_pkg.sv
// ----------------------------------------------------------------------------
// pmbb_pkg: shared types and constants of the page mode bitmap blitter
// Frame geometry, item and result words, and the per-item access plan.
// ----------------------------------------------------------------------------
package pmbb_pkg;

	localparam int FRAME_COLUMNS = 128;
	localparam int FRAME_ROWS = 64;
	localparam int PAGE_COUNT = (FRAME_ROWS + 7) / 8;
	localparam int STORE_SIZE = FRAME_COLUMNS * PAGE_COUNT;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int AT_W = 13;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int USED_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_BLIT = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ = 2'd2,
		OP_READ_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t operation;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] bitmap_height;
		logic [7:0] clip_offset;
		logic invert;
		logic [4:0] row_index;
		logic [7:0] column_index;
		logic [7:0] pixel_bits;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic wrote_upper;
		logic wrote_lower;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] up_addr;
		logic up_wr;
		logic up_clear;
		logic [7:0] up_bits;
		logic show_old;
		logic show_new;
		logic [ADDR_W-1:0] lo_addr;
		logic lo_wr;
		logic [7:0] lo_bits;
	} plan_t;

endpackage

### rtl/core/pmbb_frame_ram.sv
// ----------------------------------------------------------------------------
// pmbb_frame_ram: frame store
// One write port and one read port, read data registered, read returns old data.
// ----------------------------------------------------------------------------
module pmbb_frame_ram (
	input  logic clk,
	input  logic rd_en,
	input  logic [pmbb_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0] rd_data,
	input  logic wr_en,
	input  logic [pmbb_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0] wr_data
);

	logic [7:0] mem_q [pmbb_pkg::STORE_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/pmbb_decode.sv
// ----------------------------------------------------------------------------
// pmbb_decode: placement, clipping and masking of one item
// Turns an item into the page byte accesses that it needs.
// ----------------------------------------------------------------------------
module pmbb_decode (
	input  pmbb_pkg::in_item_t item,
	input  logic [7:0] vertical_offset,
	output pmbb_pkg::plan_t plan
);

	logic [7:0] yy;
	logic [7:0] y;
	logic [7:0] bottom;
	logic [7:0] top;
	logic [7:0] nxt;
	logic [7:0] x;
	logic [7:0] d_left;
	logic [7:0] d_right;
	logic [7:0] mask;
	logic [7:0] pixels;
	logic [15:0] placed;
	logic clipped;
	logic go;
	logic top_in;
	logic aligned;
	logic [pmbb_pkg::AT_W-1:0] upper_at;
	logic [pmbb_pkg::AT_W-1:0] lower_at;
	logic [pmbb_pkg::AT_W-1:0] target_at;
	logic target_ok;
	logic upper_ok;
	logic lower_ok;
	logic is_blit;

	always_comb begin
		yy = item.pos_y + vertical_offset;
		y = yy - item.clip_offset;
		bottom = yy + item.bitmap_height;
		top = {item.row_index, 3'b000} + y;
		nxt = top + 8'd8;
		x = item.pos_x + item.column_index;
		d_left = yy - top;
		d_right = nxt - bottom;

		mask = 8'hFF;
		if (item.clip_offset != 8'd0) begin
			if (top < yy) begin
				mask = (d_left[7:3] != 5'd0) ? 8'h00 : (8'hFF << d_left[2:0]);
			end else if (nxt > bottom) begin
				mask = (d_right[7:3] != 5'd0) ? 8'h00 : (8'hFF >> d_right[2:0]);
			end
		end

		clipped = (item.clip_offset != 8'd0) && ((nxt < yy)
			|| ({1'b0, nxt} > 9'(pmbb_pkg::FRAME_ROWS)) || (top > bottom));
		go = (item.row_index < item.bitmap_height[7:3]) && !clipped
			&& ({1'b0, x} < 9'(pmbb_pkg::FRAME_COLUMNS));

		pixels = (item.invert ? ~item.pixel_bits : item.pixel_bits) & mask;
		placed = {8'h00, pixels} << y[2:0];

		upper_at = pmbb_pkg::AT_W'(top[7:3]) * pmbb_pkg::AT_W'(pmbb_pkg::FRAME_COLUMNS)
			+ pmbb_pkg::AT_W'(x);
		lower_at = pmbb_pkg::AT_W'(nxt[7:3]) * pmbb_pkg::AT_W'(pmbb_pkg::FRAME_COLUMNS)
			+ pmbb_pkg::AT_W'(x);
		target_at = pmbb_pkg::AT_W'(item.pos_y[7:3])
			* pmbb_pkg::AT_W'(pmbb_pkg::FRAME_COLUMNS) + pmbb_pkg::AT_W'(item.pos_x);

		top_in = {1'b0, top} < 9'(pmbb_pkg::FRAME_ROWS);
		aligned = (y[2:0] == 3'd0);
		upper_ok = go && top_in && (upper_at < pmbb_pkg::AT_W'(pmbb_pkg::STORE_SIZE));
		lower_ok = go && !(aligned && top_in)
			&& ({1'b0, nxt} < 9'(pmbb_pkg::FRAME_ROWS))
			&& (lower_at < pmbb_pkg::AT_W'(pmbb_pkg::STORE_SIZE));
		target_ok = ({1'b0, item.pos_x} < 9'(pmbb_pkg::FRAME_COLUMNS))
			&& ({1'b0, item.pos_y[7:3]} < 6'(pmbb_pkg::PAGE_COUNT))
			&& (target_at < pmbb_pkg::AT_W'(pmbb_pkg::STORE_SIZE));

		is_blit = (item.operation == pmbb_pkg::OP_BLIT);

		plan.up_addr = is_blit ? upper_at[pmbb_pkg::ADDR_W-1:0]
			: target_at[pmbb_pkg::ADDR_W-1:0];
		plan.up_bits = placed[7:0];
		plan.lo_addr = lower_at[pmbb_pkg::ADDR_W-1:0];
		plan.lo_bits = placed[15:8];
		plan.lo_wr = is_blit && lower_ok;
		plan.show_new = is_blit && upper_ok;
		plan.up_clear = 1'b0;
		plan.up_wr = 1'b0;
		plan.show_old = 1'b0;
		case (item.operation)
			pmbb_pkg::OP_BLIT: begin
				plan.up_wr = upper_ok;
			end
			pmbb_pkg::OP_CLEAR: begin
				plan.up_wr = target_ok;
				plan.up_clear = 1'b1;
			end
			pmbb_pkg::OP_READ: begin
				plan.show_old = target_ok;
			end
			pmbb_pkg::OP_READ_CLEAR: begin
				plan.up_wr = target_ok;
				plan.up_clear = 1'b1;
				plan.show_old = target_ok;
			end
			default: begin
				plan.up_wr = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/page_mode_bitmap_blitter.sv
// ----------------------------------------------------------------------------
// page_mode_bitmap_blitter: monochrome page framebuffer with byte blits
// Blits, clears and reads page bytes of a column-major 8-pixel page store.
// ----------------------------------------------------------------------------
// Items enter on the item channel (item_valid, item_ready, item_word) and each
// gives exactly one result word on the result channel (res_valid, res_ready,
// res_word). The vertical offset register is written on the cfg channel, which
// is always ready; write it only while no item is in flight.
// An item uses the frame store's read port twice: once for the upper page byte
// and once for the lower, so no new item is accepted while one is in the first
// stage. Its result is pushed from the second stage into a four-word output
// queue. When the receiver stalls, the queue fills and item_ready drops once
// four results are owed; no work is lost. Reset clears the control state and
// the offset, then a clearing pass writes zero to all 1024 frame bytes, one
// per cycle, with item_ready low throughout the pass. Writes that land on a
// byte being read are forwarded.
// ----------------------------------------------------------------------------
module page_mode_bitmap_blitter (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  pmbb_pkg::in_item_t item_word,
	output logic res_valid,
	input  logic res_ready,
	output pmbb_pkg::out_item_t res_word,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_word
);

	logic [7:0] vo_q;
	logic clr_busy_q;
	logic [pmbb_pkg::ADDR_W-1:0] clr_addr_q;

	logic s1_valid_q;
	pmbb_pkg::in_item_t s1_item_s1;
	pmbb_pkg::plan_t s1_plan;
	logic s2_valid_q;
	pmbb_pkg::plan_t plan_s2;
	logic s3_valid_q;
	logic lo_wr_s3;
	logic [pmbb_pkg::ADDR_W-1:0] lo_addr_s3;
	logic [7:0] lo_bits_s3;

	logic rd_en;
	logic [pmbb_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0] ram_rd_data;
	logic wr_en;
	logic [pmbb_pkg::ADDR_W-1:0] wr_addr;
	logic [7:0] wr_data;
	logic fwd_hit_q;
	logic [7:0] fwd_data_q;
	logic [7:0] rd_eff;
	logic [7:0] new_upper;

	pmbb_pkg::out_item_t fifo_q [pmbb_pkg::OUT_DEPTH];
	logic [pmbb_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [pmbb_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [pmbb_pkg::USED_W-1:0] fifo_cnt_q;
	logic [pmbb_pkg::USED_W-1:0] used_q;
	pmbb_pkg::out_item_t push_word;
	logic accept;
	logic pop;

	assign cfg_ready = 1'b1;
	assign item_ready = !clr_busy_q && !s1_valid_q
		&& (used_q != pmbb_pkg::USED_W'(pmbb_pkg::OUT_DEPTH));
	assign accept = item_valid && item_ready;
	assign res_valid = (fifo_cnt_q != '0);
	assign res_word = fifo_q[rd_ptr_q];
	assign pop = res_valid && res_ready;

	pmbb_decode u_decode (
		.item(s1_item_s1),
		.vertical_offset(vo_q),
		.plan(s1_plan)
	);

	pmbb_frame_ram u_ram (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	always_comb begin
		rd_eff = fwd_hit_q ? fwd_data_q : ram_rd_data;
		new_upper = plan_s2.up_clear ? 8'h00 : (rd_eff | plan_s2.up_bits);

		rd_en = s1_valid_q || s2_valid_q;
		rd_addr = s1_valid_q ? s1_plan.up_addr : plan_s2.lo_addr;

		wr_en = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = 8'h00;
		if (clr_busy_q) begin
			wr_en = 1'b1;
		end else if (s2_valid_q && plan_s2.up_wr) begin
			wr_en = 1'b1;
			wr_addr = plan_s2.up_addr;
			wr_data = new_upper;
		end else if (s3_valid_q && lo_wr_s3) begin
			wr_en = 1'b1;
			wr_addr = lo_addr_s3;
			wr_data = rd_eff | lo_bits_s3;
		end

		push_word.read_data = plan_s2.show_new ? new_upper
			: (plan_s2.show_old ? rd_eff : 8'h00);
		push_word.wrote_upper = plan_s2.show_new;
		push_word.wrote_lower = plan_s2.lo_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 8'h00;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
			fwd_hit_q <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_cnt_q <= '0;
			used_q <= '0;
		end else begin
			if (cfg_valid) begin
				vo_q <= cfg_word;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == pmbb_pkg::ADDR_W'(pmbb_pkg::STORE_SIZE - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			s1_valid_q <= accept;
			s2_valid_q <= s1_valid_q;
			s3_valid_q <= s2_valid_q;
			fwd_hit_q <= rd_en && wr_en && (wr_addr == rd_addr);
			if (s2_valid_q) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + pmbb_pkg::USED_W'(s2_valid_q)
				- pmbb_pkg::USED_W'(pop);
			used_q <= used_q + pmbb_pkg::USED_W'(accept) - pmbb_pkg::USED_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
		if (accept) begin
			s1_item_s1 <= item_word;
		end
		if (s1_valid_q) begin
			plan_s2 <= s1_plan;
		end
		if (s2_valid_q) begin
			lo_wr_s3 <= plan_s2.lo_wr;
			lo_addr_s3 <= plan_s2.lo_addr;
			lo_bits_s3 <= plan_s2.lo_bits;
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	// The read port serves one stage at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_valid_q && s2_valid_q))
		else $error("s1 and s2 both hold an item");

	// Results owed never exceed the queue depth, so every push finds room.
	assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> (fifo_cnt_q != pmbb_pkg::USED_W'(pmbb_pkg::OUT_DEPTH)) || pop)
		else $error("result pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= used_q)
		else $error("queue holds more results than items owed");

	// No item enters while the clearing pass owns the write port.
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_valid_q && !s2_valid_q && !s3_valid_q)
		else $error("item in flight during the clearing pass");

endmodule

### test/tb_page_mode_bitmap_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_mode_bitmap_blitter: self-checking bench for the page bitmap blitter
// Drives blit, clear, read and read-clear words through the valid/ready item
// channel while keeping a shadow copy of the frame store and of the vertical
// offset. Each result word is checked field by field against the prediction.
// Directed corner words come first, then six random segments, each with its
// own offset; the segments share three pacing modes in pairs.
// ----------------------------------------------------------------------------
module tb_page_mode_bitmap_blitter;

	localparam int QUIET_LIMIT = 5000;
	localparam int SEG_WORDS = 316;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	pmbb_pkg::in_item_t item_word = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	pmbb_pkg::out_item_t res_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_word = 8'd0;

	bit [7:0] shadow_frame [pmbb_pkg::STORE_SIZE];
	bit [7:0] shadow_offset;
	pmbb_pkg::in_item_t item_backlog [$];
	pmbb_pkg::out_item_t owed_results [$];
	logic item_taken = 1'b0;
	int unsigned send_idle_pct = 34;
	int unsigned recv_idle_pct = 52;
	int mismatches = 0;
	int results_checked = 0;
	int op_seen [4];
	int quiet_cycles = 0;

	page_mode_bitmap_blitter uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_word(item_word),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word(res_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_word(cfg_word)
	);

	always begin
		#5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic pmbb_pkg::out_item_t predict_frame_access(input pmbb_pkg::in_item_t it);
		pmbb_pkg::out_item_t r;
		bit [7:0] yy, ys, bottom, top, nxt, x, mask, pix, diff;
		int shift, upper_at, lower_at, at;
		r = '0;
		if (it.operation != pmbb_pkg::OP_BLIT) begin
			at = int'(it.pos_y[7:3]) * pmbb_pkg::FRAME_COLUMNS + int'(it.pos_x);
			if (it.pos_x >= pmbb_pkg::FRAME_COLUMNS || it.pos_y[7:3] >= pmbb_pkg::PAGE_COUNT
					|| at >= pmbb_pkg::STORE_SIZE)
				return r;
			if (it.operation == pmbb_pkg::OP_READ || it.operation == pmbb_pkg::OP_READ_CLEAR)
				r.read_data = shadow_frame[at];
			if (it.operation == pmbb_pkg::OP_CLEAR || it.operation == pmbb_pkg::OP_READ_CLEAR)
				shadow_frame[at] = 8'h00;
			return r;
		end
		yy = it.pos_y + shadow_offset;
		ys = yy - it.clip_offset;
		bottom = yy + it.bitmap_height;
		top = {it.row_index, 3'b000} + ys;
		nxt = top + 8'd8;
		x = it.pos_x + it.column_index;
		shift = int'(ys[2:0]);
		mask = 8'hFF;
		if (it.row_index >= it.bitmap_height[7:3])
			return r;
		if (it.clip_offset != 0 && (nxt < yy || nxt > pmbb_pkg::FRAME_ROWS || top > bottom))
			return r;
		if (it.clip_offset != 0) begin
			if (top < yy) begin
				diff = yy - top;
				mask = (diff >= 8) ? 8'h00 : 8'hFF << diff;
			end else if (nxt > bottom) begin
				diff = nxt - bottom;
				mask = (diff >= 8) ? 8'h00 : 8'hFF >> diff;
			end
		end
		if (x >= pmbb_pkg::FRAME_COLUMNS)
			return r;
		pix = (it.invert ? ~it.pixel_bits : it.pixel_bits) & mask;
		upper_at = int'(top[7:3]) * pmbb_pkg::FRAME_COLUMNS + int'(x);
		lower_at = int'(nxt[7:3]) * pmbb_pkg::FRAME_COLUMNS + int'(x);
		if (shift == 0 && top < pmbb_pkg::FRAME_ROWS) begin
			if (upper_at < pmbb_pkg::STORE_SIZE) begin
				shadow_frame[upper_at] |= pix;
				r.read_data = shadow_frame[upper_at];
				r.wrote_upper = 1'b1;
			end
			return r;
		end
		if (top < pmbb_pkg::FRAME_ROWS && upper_at < pmbb_pkg::STORE_SIZE) begin
			shadow_frame[upper_at] |= pix << shift;
			r.read_data = shadow_frame[upper_at];
			r.wrote_upper = 1'b1;
		end
		if (nxt < pmbb_pkg::FRAME_ROWS && lower_at < pmbb_pkg::STORE_SIZE) begin
			shadow_frame[lower_at] |= pix >> (8 - shift);
			r.wrote_lower = 1'b1;
		end
		return r;
	endfunction

	function automatic pmbb_pkg::in_item_t item_of(input pmbb_pkg::op_t op, input bit [7:0] px,
			input bit [7:0] py, input bit [7:0] h, input bit [7:0] clip, input bit inv,
			input bit [4:0] row, input bit [7:0] col, input bit [7:0] bits);
		pmbb_pkg::in_item_t it;
		it.operation = op;
		it.pos_x = px;
		it.pos_y = py;
		it.bitmap_height = h;
		it.clip_offset = clip;
		it.invert = inv;
		it.row_index = row;
		it.column_index = col;
		it.pixel_bits = bits;
		return it;
	endfunction

	function automatic pmbb_pkg::in_item_t random_item();
		pmbb_pkg::in_item_t it;
		int pick, bands;
		bit [7:0] yy_target;
		it.operation = pmbb_pkg::op_t'($urandom_range(3));
		it.pos_x = 8'($urandom);
		it.pos_y = 8'($urandom);
		it.bitmap_height = 8'($urandom);
		it.clip_offset = 8'($urandom);
		it.invert = 1'($urandom);
		it.row_index = 5'($urandom);
		it.column_index = 8'($urandom);
		it.pixel_bits = 8'($urandom);
		if ($urandom_range(99) < 15)
			return it;
		pick = $urandom_range(99);
		if (pick < 55) begin
			it.operation = pmbb_pkg::OP_BLIT;
			bands = $urandom_range(1, 4);
			it.bitmap_height = 8'(bands * 8 + $urandom_range(0, 7));
			it.row_index = 5'($urandom_range(0, bands - 1));
			it.column_index = 8'($urandom_range(0, 15));
			it.pos_x = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 127))
				: 8'($urandom_range(0, 63));
			yy_target = 8'($urandom_range(0, 40));
			it.pos_y = yy_target - shadow_offset;
			pick = $urandom_range(99);
			if (pick < 50)
				it.clip_offset = 8'd0;
			else if (pick < 85)
				it.clip_offset = 8'($urandom_range(1, 16));
			else
				it.clip_offset = 8'($urandom_range(1, 255));
		end else begin
			if (pick < 65)
				it.operation = pmbb_pkg::OP_CLEAR;
			else if (pick < 85)
				it.operation = pmbb_pkg::OP_READ;
			else
				it.operation = pmbb_pkg::OP_READ_CLEAR;
			if ($urandom_range(9) != 0) begin
				it.pos_x = 8'($urandom_range(0, 79));
				it.pos_y = 8'($urandom_range(0, 63));
			end
		end
		return it;
	endfunction

	task automatic write_offset(input bit [7:0] value);
		@(negedge clk);
		cfg_word <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		do @(posedge clk);
		while (item_backlog.size() != 0 || item_valid || owed_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_word <= item_backlog.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		pmbb_pkg::out_item_t want;
		item_taken <= item_valid && item_ready;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				results_checked++;
				if (owed_results.size() == 0) begin
					report_mismatch("result word arrived with nothing owed");
				end else begin
					want = owed_results.pop_front();
					if (res_word.read_data !== want.read_data)
						report_mismatch($sformatf("result %0d read_data %h, predicted %h",
							results_checked, res_word.read_data, want.read_data));
					if (res_word.wrote_upper !== want.wrote_upper)
						report_mismatch($sformatf("result %0d wrote_upper %b, predicted %b",
							results_checked, res_word.wrote_upper, want.wrote_upper));
					if (res_word.wrote_lower !== want.wrote_lower)
						report_mismatch($sformatf("result %0d wrote_lower %b, predicted %b",
							results_checked, res_word.wrote_lower, want.wrote_lower));
				end
			end
			if (item_valid && item_ready) begin
				owed_results.push_back(predict_frame_access(item_word));
				op_seen[item_word.operation]++;
			end
			if (cfg_valid && cfg_ready)
				shadow_offset = cfg_word;
			if ((res_valid && res_ready) || (item_valid && item_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired at %0t with %0d results owed", $time, owed_results.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit [7:0] offsets [6];
		string offsets_text;
		offsets_text = "";
		offsets[0] = 8'd255;
		offsets[1] = 8'($urandom);
		offsets[2] = 8'd0;
		offsets[3] = 8'd8;
		offsets[4] = 8'($urandom);
		offsets[5] = 8'd128;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		write_offset(8'd0);
		@(posedge clk);
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 0, 0, 8, 0, 0, 0, 0, 8'hA5));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 10, 3, 16, 0, 0, 1, 5, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ, 15, 8, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ, 15, 16, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 20, 8, 8, 0, 1, 0, 0, 8'h0F));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 1, 0, 15, 0, 0, 1, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 1, 0, 0, 0, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 200, 0, 8, 0, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 255, 0, 8, 0, 0, 0, 2, 8'h3C));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 30, 20, 24, 3, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 31, 10, 10, 250, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 32, 30, 8, 8, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 33, 60, 16, 1, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 34, 30, 8, 20, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 35, 250, 8, 0, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 36, 248, 8, 0, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 37, 60, 8, 0, 0, 0, 0, 8'hFF));
		item_backlog.push_back(item_of(pmbb_pkg::OP_BLIT, 127, 56, 255, 0, 1, 30, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ_CLEAR, 15, 8, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ, 15, 8, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ, 128, 0, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_CLEAR, 255, 255, 0, 0, 0, 0, 0, 8'h00));
		item_backlog.push_back(item_of(pmbb_pkg::OP_READ_CLEAR, 5, 64, 0, 0, 0, 0, 0, 8'h00));
		drain_results();
		for (int seg = 0; seg < 6; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 34;
				recv_idle_pct = 52;
			end else if (seg < 4) begin
				send_idle_pct = 52;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_offset(offsets[seg]);
			offsets_text = {offsets_text, $sformatf(" %0d", offsets[seg])};
			@(posedge clk);
			for (int n = 0; n < SEG_WORDS; n++) begin
				if (seg == 1 && n == SEG_WORDS / 2)
					drain_results();
				item_backlog.push_back(random_item());
			end
			drain_results();
		end
		$display("covered %0d blit, %0d clear, %0d read and %0d read-clear words; %0d %s",
			op_seen[pmbb_pkg::OP_BLIT], op_seen[pmbb_pkg::OP_CLEAR],
			op_seen[pmbb_pkg::OP_READ], op_seen[pmbb_pkg::OP_READ_CLEAR],
			results_checked, "results checked");
		$display("vertical offsets used: 0%s, under three pacing modes; %0d mismatches",
			offsets_text, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
